FILE: rtl/eoln_pkg.sv
// package: character codes, widths and the command record passed from front to back
`timescale 1ns / 1ps

package eoln_pkg;

  localparam int CharW  = 21;
  localparam int CountW = 32;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [CharW-1:0]  ChLf    = 21'h00000A;
  localparam logic [CharW-1:0]  ChCr    = 21'h00000D;
  localparam logic [CharW-1:0]  ChNel   = 21'h000085;
  localparam logic [CharW-1:0]  ChLs    = 21'h002028;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic ModePass = 1'b0;
  localparam logic ModeNorm = 1'b1;

  // work for the back end: an optional LF for a held CR, then an optional main result
  typedef struct packed {
    logic              flush;
    logic [CountW-1:0] flush_cnt;
    logic              main_vld;
    logic [CharW-1:0]  main_char;
    logic              main_end;
    logic [CountW-1:0] main_cnt;
  } eoln_cmd_t;

endpackage

FILE: rtl/eoln_front.sv
// front end: accepts characters, tracks held CR and line count, builds commands
`timescale 1ns / 1ps

module eoln_front
  import eoln_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CharW-1:0] in_char_code,
  input  logic             in_end_of_stream,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_eol_mode,
  input  logic             q_full,
  output logic             q_push,
  output eoln_cmd_t        q_cmd
);

  logic              mode_r, mode_nxt;
  logic              pend_r, pend_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [CountW-1:0] cnt_inc;
  logic              accept;
  logic              is_lf, is_nel, is_ls, is_cr;
  eoln_cmd_t         cmd;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign is_lf  = (in_char_code == ChLf);
  assign is_nel = (in_char_code == ChNel);
  assign is_ls  = (in_char_code == ChLs);
  assign is_cr  = (in_char_code == ChCr);

  assign cnt_inc = (cnt_r == CountMax) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    cmd.flush     = pend_r;
    cmd.flush_cnt = cnt_r;
    cmd.main_vld  = 1'b1;
    cmd.main_char = in_char_code;
    cmd.main_end  = 1'b0;
    cmd.main_cnt  = cnt_r;
    pend_nxt      = 1'b0;
    cnt_nxt       = cnt_r;
    if (in_end_of_stream) begin
      cmd.main_char = '0;
      cmd.main_end  = 1'b1;
    end else if (mode_r == ModePass) begin
      if (is_lf) begin
        cnt_nxt      = cnt_inc;
        cmd.main_cnt = cnt_inc;
      end
    end else if (pend_r && (is_lf || is_nel)) begin
      cmd.main_vld = 1'b0;
    end else if (is_lf || is_nel || is_ls) begin
      cnt_nxt       = cnt_inc;
      cmd.main_char = ChLf;
      cmd.main_cnt  = cnt_inc;
    end else if (is_cr) begin
      cnt_nxt      = cnt_inc;
      pend_nxt     = 1'b1;
      cmd.main_vld = 1'b0;
    end
  end

  assign mode_nxt = (cfg_valid && cfg_ready) ? cfg_eol_mode : mode_r;
  assign q_push   = accept && (cmd.flush || cmd.main_vld);
  assign q_cmd    = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeNorm;
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      if (accept) begin
        pend_r <= pend_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

FILE: rtl/eoln_queue.sv
// command queue between front and back ends
`timescale 1ns / 1ps

module eoln_queue
  import eoln_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  eoln_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_vld,
  output eoln_cmd_t head_cmd
);

  eoln_cmd_t        mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]   fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full     = (fill_r == (QPtrW+1)'(QDepth));
  assign head_vld = (fill_r != '0);
  assign head_cmd = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  always_comb begin
    fill_nxt = fill_r;
    case ({do_push, do_pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

FILE: rtl/eoln_back.sv
// back end: expands each command into one or two output transactions
`timescale 1ns / 1ps

module eoln_back
  import eoln_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_vld,
  input  eoln_cmd_t         head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CharW-1:0]  out_out_char,
  output logic              out_stream_end,
  output logic              out_last_of_run,
  output logic [CountW-1:0] out_line_count
);

  eoln_cmd_t cmd_r;
  logic      cmd_vld_r, cmd_vld_nxt;
  logic      phase_r, phase_nxt;
  logic      show_flush;
  logic      fire, done, load;

  assign show_flush = !phase_r && cmd_r.flush;
  assign fire       = cmd_vld_r && out_ready;
  assign done       = fire && !(show_flush && cmd_r.main_vld);
  assign load       = !cmd_vld_r || done;
  assign pop        = load && head_vld;

  always_comb begin
    cmd_vld_nxt = cmd_vld_r;
    phase_nxt   = phase_r;
    if (load) begin
      cmd_vld_nxt = head_vld;
      phase_nxt   = 1'b0;
    end else if (fire) begin
      phase_nxt = 1'b1;
    end
  end

  assign out_valid       = cmd_vld_r;
  assign out_out_char    = show_flush ? ChLf : cmd_r.main_char;
  assign out_stream_end  = show_flush ? 1'b0 : cmd_r.main_end;
  assign out_last_of_run = show_flush ? !cmd_r.main_vld : 1'b1;
  assign out_line_count  = show_flush ? cmd_r.flush_cnt : cmd_r.main_cnt;

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
      phase_r   <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
      phase_r   <= phase_nxt;
    end
  end

endmodule

FILE: rtl/eol_normalizer.sv
// top level: line-ending normalizer with decoupled front end, queue and back end
//
//   channel  direction  handshake             payload
//   in_      input      in_valid/in_ready     in_char_code, in_end_of_stream
//   out_     output     out_valid/out_ready   out_out_char, out_stream_end,
//                                             out_last_of_run, out_line_count
//   cfg_     input      cfg_valid/cfg_ready   cfg_eol_mode
//
// one transaction per cycle each way unless stalled (queue full, out_ready low);
// an input that gives two results (held CR flushed ahead of a character or
// terminator) uses two output transactions; input is taken whenever the
// four-entry command queue has room; results are registered in the back end
// rst_n clears the queue, held CR and line count and sets the mode to normalize
`timescale 1ns / 1ps

module eol_normalizer
  import eoln_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CharW-1:0]  in_char_code,
  input  logic              in_end_of_stream,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CharW-1:0]  out_out_char,
  output logic              out_stream_end,
  output logic              out_last_of_run,
  output logic [CountW-1:0] out_line_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_eol_mode
);

  logic      q_full, q_push, q_pop, q_head_vld;
  eoln_cmd_t q_cmd, q_head_cmd;

  eoln_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_stream (in_end_of_stream),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_eol_mode     (cfg_eol_mode),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  eoln_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_vld (q_head_vld),
    .head_cmd (q_head_cmd)
  );

  eoln_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_vld        (q_head_vld),
    .head_cmd        (q_head_cmd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_char    (out_out_char),
    .out_stream_end  (out_stream_end),
    .out_last_of_run (out_last_of_run),
    .out_line_count  (out_line_count)
  );

endmodule

FILE: verif/eol_normalizer_check.sv
// checker: predicts eol normalizer results from observed transactions and compares them
`timescale 1ns / 1ps

module eol_normalizer_check
  import eoln_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CharW-1:0]  in_char_code,
  input  logic              in_end_of_stream,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CharW-1:0]  out_out_char,
  input  logic              out_stream_end,
  input  logic              out_last_of_run,
  input  logic [CountW-1:0] out_line_count,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_eol_mode,
  output int unsigned       fail_count,
  output int unsigned       outstanding,
  output int unsigned       results_checked
);

  localparam int unsigned PrintLimit = 100;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              term;
    logic              last;
    logic [CountW-1:0] cnt;
  } eol_result_t;

  eol_result_t       pending_results[$];
  eol_result_t       run_results[$];
  logic              eol_mode;
  logic              cr_held;
  logic [CountW-1:0] lines;

  function automatic void count_line();
    if (lines != CountMax) lines = lines + 1'b1;
  endfunction

  function automatic void stage(input logic [CharW-1:0] ch, input logic term);
    run_results.push_back('{ch: ch, term: term, last: 1'b0, cnt: lines});
  endfunction

  // one input transaction: update held CR and line count, queue its results
  function automatic void fold_char(input logic [CharW-1:0] c, input logic eos);
    logic paired;
    paired = 1'b0;
    run_results.delete();
    if (eos) begin
      if (cr_held) begin
        cr_held = 1'b0;
        stage(ChLf, 1'b0);
      end
      stage('0, 1'b1);
    end else if (eol_mode == ModePass) begin
      if (cr_held) begin
        cr_held = 1'b0;
        stage(ChLf, 1'b0);
      end
      if (c == ChLf) count_line();
      stage(c, 1'b0);
    end else begin
      if (cr_held) begin
        cr_held = 1'b0;
        stage(ChLf, 1'b0);
        paired = (c == ChLf) || (c == ChNel);
      end
      if (!paired) begin
        if (c == ChLf || c == ChNel || c == ChLs) begin
          count_line();
          stage(ChLf, 1'b0);
        end else if (c == ChCr) begin
          count_line();
          cr_held = 1'b1;
        end else begin
          stage(c, 1'b0);
        end
      end
    end
    if (run_results.size() != 0) run_results[run_results.size() - 1].last = 1'b1;
    foreach (run_results[i]) pending_results.push_back(run_results[i]);
  endfunction

  task automatic check_field(input string field, input logic [CountW-1:0] want,
                             input logic [CountW-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= PrintLimit)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    eol_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      eol_mode = ModeNorm;
      cr_held = 1'b0;
      lines = '0;
    end else begin
      if (cfg_valid && cfg_ready) eol_mode = cfg_eol_mode;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= PrintLimit)
            $display("%0t: result with none pending, expected nothing, actual char %h end %b",
                     $time, out_out_char, out_stream_end);
        end else begin
          want = pending_results.pop_front();
          check_field("out_char", CountW'(want.ch), CountW'(out_out_char));
          check_field("stream_end", CountW'(want.term), CountW'(out_stream_end));
          check_field("last_of_run", CountW'(want.last), CountW'(out_last_of_run));
          check_field("line_count", want.cnt, out_line_count);
          results_checked++;
        end
      end
      if (in_valid && in_ready) fold_char(in_char_code, in_end_of_stream);
    end
    outstanding = pending_results.size();
  end

endmodule

FILE: verif/eol_normalizer_test.sv
// testbench top: clock, reset, stimulus, back-pressure and verdict for the eol normalizer
`timescale 1ns / 1ps

module eol_normalizer_test;
  import eoln_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseItems  = 140;
  localparam int unsigned Phases      = 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CharW-1:0]  in_char_code;
  logic              in_end_of_stream;
  logic              out_valid;
  logic              out_ready;
  logic [CharW-1:0]  out_out_char;
  logic              out_stream_end;
  logic              out_last_of_run;
  logic [CountW-1:0] out_line_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_eol_mode;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned sent_items;
  int unsigned mode_writes;
  int unsigned send_gap_pct;
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned cycles;

  eol_normalizer u_dut (.*);

  eol_normalizer_check u_check (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("run timed out after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(input logic [CharW-1:0] code, input logic eos);
    in_valid <= 1'b1;
    in_char_code <= code;
    in_end_of_stream <= eos;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent_items++;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_eol_mode <= mode;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // text-like traffic with line endings, pairs, stream ends and raw code points
  task automatic send_text_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_item(CharW'($urandom_range(32, 126)), 1'b0);
    end else if (pick < 45) begin
      send_item(ChLf, 1'b0);
    end else if (pick < 53) begin
      send_item(ChCr, 1'b0);
    end else if (pick < 58) begin
      send_item(ChNel, 1'b0);
    end else if (pick < 62) begin
      send_item(ChLs, 1'b0);
    end else if (pick < 70) begin
      send_item(ChCr, 1'b0);
      send_item(ChLf, 1'b0);
    end else if (pick < 74) begin
      send_item(ChCr, 1'b0);
      send_item(ChNel, 1'b0);
    end else if (pick < 77) begin
      send_item(CharW'($urandom), 1'b1);
    end else if (pick < 90) begin
      send_item(CharW'($urandom), 1'b0);
    end else begin
      send_item(CharW'($urandom_range(128, 32'h10FFFF)), 1'b0);
    end
  endtask

  // receiver: random stall rate per stretch, long hold when asked
  initial begin
    int unsigned stall_pct;
    int unsigned span;
    int unsigned n;
    stall_pct = 0;
    span = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (span == 0) begin
        span = $urandom_range(100, 300);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      if (hold_reqs != holds_done) begin
        out_ready <= 1'b0;
        n = HoldCycles;
        holds_done++;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        n = pick_gap();
      end else begin
        out_ready <= 1'b1;
        n = 1;
      end
      repeat (n) @(posedge clk);
      span = (span > n) ? span - n : 0;
    end
  end

  initial begin
    int unsigned half;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_code <= '0;
    in_end_of_stream <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_eol_mode <= ModeNorm;
    sent_items = 0;
    mode_writes = 0;
    send_gap_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(ModeNorm);
    send_gap_pct = 10;
    send_item(21'h000041, 1'b0);
    send_item(21'h000000, 1'b0);
    send_item(21'h1FFFFF, 1'b0);
    send_item(21'h10FFFF, 1'b0);
    send_item(ChLf, 1'b0);
    send_item(ChNel, 1'b0);
    send_item(ChLs, 1'b0);
    send_item(21'h002029, 1'b0);
    send_item(ChCr, 1'b0);
    send_item(ChLf, 1'b0);
    send_item(ChCr, 1'b0);
    send_item(ChNel, 1'b0);
    send_item(ChCr, 1'b0);
    send_item(ChCr, 1'b0);
    send_item(21'h000078, 1'b0);
    send_item(ChCr, 1'b0);
    send_item(21'h000000, 1'b1);
    send_item(21'h1FFFFF, 1'b1);
    send_item(ChCr, 1'b0);
    // CR still held when switching to pass-through
    write_mode(ModePass);
    send_item(21'h000079, 1'b0);
    send_item(ChCr, 1'b0);
    send_item(ChLf, 1'b0);
    send_item(ChNel, 1'b0);
    send_item(ChLs, 1'b0);
    send_item(21'h000000, 1'b1);

    for (int p = 0; p < Phases; p++) begin
      write_mode((p % 3 == 1) ? ModePass : ModeNorm);
      case (p % 4)
        0: send_gap_pct = 0;
        1: send_gap_pct = 10;
        2: send_gap_pct = 25;
        default: send_gap_pct = 50;
      endcase
      if (p == 2) send_gap_pct = 0;
      half = sent_items + PhaseItems / 2;
      while (sent_items < half) send_text_item();
      if (p == 2) hold_reqs <= hold_reqs + 1;
      if (p == 5) drain();
      half = sent_items + PhaseItems / 2;
      while (sent_items < half) send_text_item();
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    $display("%0d input transactions, %0d results checked, %0d mode writes",
             sent_items, results_checked, mode_writes);
    $display("both modes, CR pairs and flushes, stream ends, stalls and a long output hold");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
